// ----- rtl/core/e2j_pkg.sv -----
`timescale 1ns / 1ps
// EUC-JP to ISO-2022-JP encoder: shared types, codes and the escape table.
// No dependencies; used by the top level, front, queue and back.

package e2j_pkg;

  // Operation codes on the input channel
  localparam logic OpData  = 1'b0;
  localparam logic OpFlush = 1'b1;

  // Result status codes
  localparam logic [1:0] StatByte       = 2'd0;
  localparam logic [1:0] StatIllegal    = 2'd1;
  localparam logic [1:0] StatIncomplete = 2'd2;

  // Designated character sets
  localparam logic [1:0] SetRoman = 2'd0;
  localparam logic [1:0] SetX0208 = 2'd1;
  localparam logic [1:0] SetKana  = 2'd2;
  localparam logic [1:0] SetX0212 = 2'd3;

  // Pending multi-byte character kinds
  localparam logic [1:0] PendNone  = 2'd0;
  localparam logic [1:0] PendX0208 = 2'd1;
  localparam logic [1:0] PendSs2   = 2'd2;
  localparam logic [1:0] PendSs3   = 2'd3;

  localparam logic [6:0] EscCode = 7'h1B;

  localparam int unsigned QueueDepth = 4;

  // One command from the front to the back: an optional status beat, an
  // optional escape and up to two character bytes, sent in that order.
  typedef struct packed {
    logic       stat_en;
    logic [1:0] stat;
    logic       esc_en;
    logic [1:0] esc_set;
    logic [1:0] n_data;
    logic [6:0] d0;
    logic [6:0] d1;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [2:0] esc_len(input logic [1:0] set);
    return (set == SetX0212) ? 3'd4 : 3'd3;
  endfunction

  // Byte j of the escape sequence that designates the given set
  function automatic logic [6:0] esc_byte(input logic [1:0] set, input logic [1:0] j);
    logic [6:0] b;
    b = EscCode;
    unique case (j)
      2'd0: b = EscCode;
      2'd1: b = (set == SetX0208 || set == SetX0212) ? 7'h24 : 7'h28;
      2'd2: begin
        unique case (set)
          SetRoman: b = 7'h4A;
          SetX0208: b = 7'h42;
          SetKana:  b = 7'h49;
          default:  b = 7'h28;
        endcase
      end
      default: b = 7'h44;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/e2j_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the encoder's input and output beats.
// No dependencies.

interface e2j_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface e2j_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// ----- rtl/core/eucjp_to_iso2022jp_encoder_core.sv -----
`timescale 1ns / 1ps
// EUC-JP to ISO-2022-JP encoder, top level.
// Depends on e2j_pkg, e2j_if, e2j_front, e2j_queue and e2j_back.
//
//   Channel | Dir | Beat payload               | Handshake
//   in_i    | in  | operation, data_byte       | valid/ready
//   out_o   | out | out_byte, status, last     | valid/ready
//
// The front takes one input beat per cycle while the command queue has room.
// The back sends one result beat per cycle while out_o is ready: a command gives
// one beat per result (up to six for an escape followed by a double-byte
// character), so the sustained input rate follows each character's result count.
// A result passes through the command queue and the back's output register
// before it is on out_o.
// Reset (rst_ni low, asynchronous) returns to the Roman set with nothing pending.
// A stalled output holds its beat; the queue lets input flow meanwhile.

module eucjp_to_iso2022jp_encoder_core #(
  parameter int unsigned QueueDepth = e2j_pkg::QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  e2j_in_if.sink    in_i,
  e2j_out_if.source out_o
);

  logic                   push, pop;
  e2j_pkg::cmd_t          cmd, head;
  e2j_pkg::queue_status_t q_status;

  // Front: byte classification and the designated-set / pending-byte state.
  e2j_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  // Decouples the two ends so an escape burst does not stall input at once.
  e2j_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  // Back: status, escape and character beats, one per cycle while out_o is ready.
  e2j_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!q_status.empty),
    .pop_o        (pop),
    .out_o        (out_o)
  );

  // An illegal sequence is always the only result of its beat.
  a_illegal_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == e2j_pkg::StatIllegal) |-> out_o.last)
    else $error("illegal-sequence beat not marked last");

  // Status beats carry no byte.
  a_status_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != e2j_pkg::StatByte) |-> (out_o.out_byte == 7'd0))
    else $error("status beat carries a byte");

  // A new output beat only follows a queued command.
  a_from_queue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!q_status.empty))
    else $error("output beat without a queued command");

  // The queue never pops when empty.
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("queue popped while empty");

endmodule

// ----- rtl/core/e2j_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts EUC-JP beats, tracks set and pending bytes, issues commands.
// Depends on e2j_pkg and e2j_in_if.

module e2j_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  e2j_in_if.sink                 in_i,
  input  e2j_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output e2j_pkg::cmd_t          cmd_o
);

  logic [1:0] cur_set_q, cur_set_d;
  logic [1:0] pend_kind_q, pend_kind_d;
  logic       pend_cnt_q, pend_cnt_d;
  logic [6:0] held_q;
  logic       held_we;
  logic       accept;
  logic [7:0] b;
  logic       b_gr, b_kana;
  e2j_pkg::cmd_t cmd;

  assign in_i.ready = !q_status_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign b_gr       = (b >= 8'hA1) && (b <= 8'hFE);
  assign b_kana     = (b >= 8'hA1) && (b <= 8'hDF);

  always_comb begin
    cmd         = '0;
    cmd.d0      = b[6:0];
    cmd.d1      = b[6:0];
    cur_set_d   = cur_set_q;
    pend_kind_d = pend_kind_q;
    pend_cnt_d  = pend_cnt_q;
    held_we     = 1'b0;

    if (in_i.operation == e2j_pkg::OpFlush) begin
      cmd.stat_en = (pend_kind_q != e2j_pkg::PendNone);
      cmd.stat    = e2j_pkg::StatIncomplete;
      cmd.esc_en  = (cur_set_q != e2j_pkg::SetRoman);
      cmd.esc_set = e2j_pkg::SetRoman;
      cur_set_d   = e2j_pkg::SetRoman;
      pend_kind_d = e2j_pkg::PendNone;
      pend_cnt_d  = 1'b0;
    end else begin
      unique case (pend_kind_q)
        e2j_pkg::PendNone: begin
          if (!b[7]) begin
            cmd.esc_en  = (cur_set_q != e2j_pkg::SetRoman);
            cmd.esc_set = e2j_pkg::SetRoman;
            cmd.n_data  = 2'd1;
            cur_set_d   = e2j_pkg::SetRoman;
          end else if (b_gr) begin
            held_we     = 1'b1;
            pend_kind_d = e2j_pkg::PendX0208;
            pend_cnt_d  = 1'b1;
          end else if (b == 8'h8E) begin
            pend_kind_d = e2j_pkg::PendSs2;
          end else if (b == 8'h8F) begin
            pend_kind_d = e2j_pkg::PendSs3;
            pend_cnt_d  = 1'b0;
          end else begin
            cmd.stat_en = 1'b1;
            cmd.stat    = e2j_pkg::StatIllegal;
          end
        end
        e2j_pkg::PendX0208: begin
          if (b_gr) begin
            cmd.esc_en  = (cur_set_q != e2j_pkg::SetX0208);
            cmd.esc_set = e2j_pkg::SetX0208;
            cmd.n_data  = 2'd2;
            cmd.d0      = held_q;
            cur_set_d   = e2j_pkg::SetX0208;
          end else begin
            cmd.stat_en = 1'b1;
            cmd.stat    = e2j_pkg::StatIllegal;
          end
          pend_kind_d = e2j_pkg::PendNone;
          pend_cnt_d  = 1'b0;
        end
        e2j_pkg::PendSs2: begin
          if (b_kana) begin
            cmd.esc_en  = (cur_set_q != e2j_pkg::SetKana);
            cmd.esc_set = e2j_pkg::SetKana;
            cmd.n_data  = 2'd1;
            cur_set_d   = e2j_pkg::SetKana;
          end else begin
            cmd.stat_en = 1'b1;
            cmd.stat    = e2j_pkg::StatIllegal;
          end
          pend_kind_d = e2j_pkg::PendNone;
          pend_cnt_d  = 1'b0;
        end
        default: begin
          if (!b_gr) begin
            cmd.stat_en = 1'b1;
            cmd.stat    = e2j_pkg::StatIllegal;
            pend_kind_d = e2j_pkg::PendNone;
            pend_cnt_d  = 1'b0;
          end else if (!pend_cnt_q) begin
            held_we    = 1'b1;
            pend_cnt_d = 1'b1;
          end else begin
            cmd.esc_en  = (cur_set_q != e2j_pkg::SetX0212);
            cmd.esc_set = e2j_pkg::SetX0212;
            cmd.n_data  = 2'd2;
            cmd.d0      = held_q;
            cur_set_d   = e2j_pkg::SetX0212;
            pend_kind_d = e2j_pkg::PendNone;
            pend_cnt_d  = 1'b0;
          end
        end
      endcase
    end
  end

  // Beats that only start or continue a character leave nothing to send.
  assign push_o = accept && (cmd.stat_en || cmd.esc_en || (cmd.n_data != 2'd0));
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_set_q   <= e2j_pkg::SetRoman;
      pend_kind_q <= e2j_pkg::PendNone;
      pend_cnt_q  <= 1'b0;
    end else if (accept) begin
      cur_set_q   <= cur_set_d;
      pend_kind_q <= pend_kind_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && held_we) begin
      held_q <= b[6:0];
    end
  end

endmodule

// ----- rtl/core/e2j_queue.sv -----
`timescale 1ns / 1ps
// Command queue between front and back ends; push and pop in one cycle allowed.
// Depends on e2j_pkg.

module e2j_queue #(
  parameter int unsigned Depth = e2j_pkg::QueueDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  e2j_pkg::cmd_t          cmd_i,
  input  logic                   pop_i,
  output e2j_pkg::cmd_t          head_o,
  output e2j_pkg::queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  e2j_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wrap_inc(wr_q);
      if (pop_i)  rd_q <= wrap_inc(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

endmodule

// ----- rtl/core/e2j_back.sv -----
`timescale 1ns / 1ps
// Back end: expands each command into result beats behind an output register.
// Depends on e2j_pkg and e2j_out_if.

module e2j_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  e2j_pkg::cmd_t head_i,
  input  logic          head_valid_i,
  output logic          pop_o,
  e2j_out_if.source     out_o
);

  logic [2:0] idx_q;
  logic [2:0] e_len, total, j, k;
  logic       advance, is_last;
  logic [6:0] byte_d, byte_q;
  logic [1:0] stat_d, stat_q;
  logic       valid_q, last_q;

  assign e_len   = head_i.esc_en ? e2j_pkg::esc_len(head_i.esc_set) : 3'd0;
  assign total   = {2'b00, head_i.stat_en} + e_len + {1'b0, head_i.n_data};
  assign j       = idx_q - {2'b00, head_i.stat_en};
  assign k       = j - e_len;
  assign is_last = (idx_q == total - 3'd1);
  assign advance = head_valid_i && (!valid_q || out_o.ready);
  assign pop_o   = advance && is_last;

  always_comb begin
    stat_d = e2j_pkg::StatByte;
    byte_d = '0;
    if (head_i.stat_en && (idx_q == 3'd0)) begin
      stat_d = head_i.stat;
    end else if (j < e_len) begin
      byte_d = e2j_pkg::esc_byte(head_i.esc_set, j[1:0]);
    end else begin
      byte_d = k[0] ? head_i.d1 : head_i.d0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else if (advance) begin
      idx_q   <= is_last ? 3'd0 : idx_q + 3'd1;
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q <= byte_d;
      stat_q <= stat_d;
      last_q <= is_last;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.out_byte = byte_q;
  assign out_o.status   = stat_q;
  assign out_o.last     = last_q;

endmodule
